// ===== sv/wss_pkg.sv =====
// Shared types and constants for the windowed sensor statistics block.
package wss_pkg;

  // Result value width, config register width, reset values
  localparam int unsigned StatW         = 17;
  localparam int unsigned CfgW          = 7;
  localparam int unsigned MaxWindowDef  = 64;
  localparam logic [CfgW-1:0] WindowLenRst = 7'd64;
  localparam int unsigned NumChan       = 4;

  // Input field widths
  localparam int unsigned TempW  = 11;
  localparam int unsigned HumW   = 10;
  localparam int unsigned LightW = 12;
  localparam int unsigned GasW   = 16;

  // Result channel codes
  typedef enum logic [1:0] {
    CH_TEMP  = 2'd0,
    CH_HUM   = 2'd1,
    CH_LIGHT = 2'd2,
    CH_GAS   = 2'd3
  } chan_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_START,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  // Control from the sequencer to every lane
  typedef struct packed {
    logic clear;      // new sample stored: restart the accumulators
    logic rd_vld;     // ring read data is valid this cycle
    logic div_start;  // launch the mean division
  } lane_ctl_t;

endpackage

// ===== sv/wss_if.sv =====
// Handshake interfaces for the sample, result and configuration channels.
interface wss_sample_if;
  import wss_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [TempW-1:0]   temperature_tenths;
  logic        [HumW-1:0]    humidity_tenths;
  logic        [LightW-1:0]  light_level;
  logic        [GasW-1:0]    gas_ppb;
  logic                      gas_ok;
  logic                      climate_ok;

  modport source (output valid, temperature_tenths, humidity_tenths, light_level,
                  gas_ppb, gas_ok, climate_ok, input ready);
  modport sink   (input valid, temperature_tenths, humidity_tenths, light_level,
                  gas_ppb, gas_ok, climate_ok, output ready);
endinterface

interface wss_result_if;
  import wss_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [1:0]        channel;
  logic signed [StatW-1:0]  minimum;
  logic signed [StatW-1:0]  maximum;
  logic signed [StatW-1:0]  mean;
  logic                     stat_valid;
  logic        [CfgW-1:0]   entries_used;
  logic                     last_of_run;

  modport source (output valid, channel, minimum, maximum, mean, stat_valid,
                  entries_used, last_of_run, input ready);
  modport sink   (input valid, channel, minimum, maximum, mean, stat_valid,
                  entries_used, last_of_run, output ready);
endinterface

interface wss_cfg_if;
  import wss_pkg::*;
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] window_length;

  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);
endinterface

// ===== sv/wss_ram.sv =====
// Generic simple dual-port RAM with registered read.
module wss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/wss_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating signed result.
module wss_div #(
  parameter int unsigned DvdW = 24,
  parameter int unsigned DvsW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,  // magnitude
  input  logic [DvsW-1:0] divisor_i,
  input  logic            neg_i,       // negate the quotient
  output logic [DvdW-1:0] quot_o,
  output logic            busy_o
);

  localparam int unsigned StepW = $clog2(DvdW + 1);

  logic [DvdW-1:0]  dvd_q, dvd_d;
  logic [DvsW-1:0]  rem_q, rem_d;
  logic [DvsW-1:0]  dvs_q;
  logic             neg_q;
  logic [StepW-1:0] step_q, step_d;
  logic [DvsW:0]    trial;
  logic [DvsW:0]    diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dvd_q[DvdW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
    dvd_d = {dvd_q[DvdW-2:0], fits};
    rem_d = fits ? diff[DvsW-1:0] : trial[DvsW-1:0];
    step_d = step_q - StepW'(1);
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= StepW'(DvdW);
    end else if (step_q != '0) begin
      step_q <= step_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= neg_i;
    end else if (step_q != '0) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (step_q != '0);
  assign quot_o = neg_q ? (~dvd_q + DvdW'(1)) : dvd_q;

endmodule

// ===== sv/wss_lane.sv =====
// One channel lane: sample ring, min/max/sum walk and mean divider.
module wss_lane
  import wss_pkg::*;
#(
  parameter int unsigned MaxWindow = MaxWindowDef,
  parameter int unsigned ValW      = 11,
  parameter bit          SignedVal = 1'b0,
  localparam int unsigned AddrW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1,
  localparam int unsigned CntW  = $clog2(MaxWindow + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctl_t               ctl_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic [ValW-1:0]         wval_i,
  input  logic                    wflag_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic signed [StatW-1:0] min_o,
  output logic signed [StatW-1:0] max_o,
  output logic signed [StatW-1:0] mean_o,
  output logic [CntW-1:0]         cnt_o,
  output logic                    busy_o
);

  localparam int unsigned SumW = StatW + CntW;

  logic [ValW:0]            rdata;
  logic signed [StatW-1:0]  rval;
  logic                     rflag;
  logic signed [StatW-1:0]  min_q, max_q;
  logic signed [SumW-1:0]   sum_q;
  logic [CntW-1:0]          cnt_q;
  logic [SumW-1:0]          mag;
  logic [SumW-1:0]          quot;

  wss_ram #(
    .Width (ValW + 1),
    .Depth (MaxWindow)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i ({wflag_i, wval_i}),
    .raddr_i (raddr_i),
    .rdata_o (rdata)
  );

  // Extend the stored value to the result width
  assign rflag = rdata[ValW];
  assign rval  = SignedVal ? {{(StatW-ValW){rdata[ValW-1]}}, rdata[ValW-1:0]}
                           : {{(StatW-ValW){1'b0}}, rdata[ValW-1:0]};

  // Entry count, cleared for each new walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.clear) begin
      cnt_q <= '0;
    end else if (ctl_i.rd_vld && rflag) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Accumulate min, max and sum over flagged entries
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      sum_q <= '0;
    end else if (ctl_i.rd_vld && rflag) begin
      sum_q <= sum_q + {{(SumW-StatW){rval[StatW-1]}}, rval};
      if (cnt_q == '0 || rval < min_q) begin
        min_q <= rval;
      end
      if (cnt_q == '0 || rval > max_q) begin
        max_q <= rval;
      end
    end
  end

  // Divide the magnitude, restore the sign afterwards
  assign mag = sum_q[SumW-1] ? (~sum_q + SumW'(1)) : sum_q;

  wss_div #(
    .DvdW (SumW),
    .DvsW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (mag),
    .divisor_i  (cnt_q),
    .neg_i      (sum_q[SumW-1]),
    .quot_o     (quot),
    .busy_o     (busy_o)
  );

  assign min_o  = min_q;
  assign max_o  = max_q;
  assign mean_o = quot[StatW-1:0];
  assign cnt_o  = cnt_q;

endmodule

// ===== sv/windowed_sensor_statistics_top.sv =====
// Windowed min/max/mean over four sensor channels: ring control, lanes, merge.
// A stored sample is written to the ring, then the stored entries are walked
// (scan, drain), the bit-serial mean dividers run (SumW = 17 + clog2(MaxWindow+1),
// 24 by default) and the four results are emitted. No new sample is taken until
// the gas result is loaded. A sample with a bad climate reading is accepted but dropped.
// Reset: write position and fill count clear, window length returns to 64; ring
// contents are not cleared.
module windowed_sensor_statistics_top
  import wss_pkg::*;
#(
  parameter int unsigned MaxWindow = MaxWindowDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wss_sample_if.sink    sample_i,
  wss_result_if.source  result_o,
  wss_cfg_if.sink       cfg_i
);

  localparam int unsigned AddrW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned CntW  = $clog2(MaxWindow + 1);
  localparam int unsigned LenW  = (CntW > CfgW) ? CntW : CfgW;

  state_e state_q, state_d;

  logic [CfgW-1:0]  cfg_len_q;
  logic [AddrW-1:0] wp_q, wp_d, wp_eff;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [LenW-1:0]  len, wl_ext, wp_inc;
  logic [CntW-1:0]  addr_q;
  logic             rd_vld_q;
  chan_e            chan_q;

  logic accept, store, rd_issue, addr_last, lanes_busy, load;
  lane_ctl_t ctl;

  logic signed [StatW-1:0] lane_min  [NumChan];
  logic signed [StatW-1:0] lane_max  [NumChan];
  logic signed [StatW-1:0] lane_mean [NumChan];
  logic [CntW-1:0]         lane_cnt  [NumChan];
  logic [NumChan-1:0]      lane_busy;

  logic                    out_valid_q;
  logic [1:0]              out_chan_q;
  logic signed [StatW-1:0] out_min_q, out_max_q, out_mean_q;
  logic                    out_sv_q, out_last_q;
  logic [CfgW-1:0]         out_used_q;

  // Configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= WindowLenRst;
    end else if (cfg_i.valid) begin
      cfg_len_q <= cfg_i.window_length;
    end
  end

  // Active window length, wrapped write position and saturating fill
  always_comb begin
    wl_ext = LenW'(cfg_len_q);
    if (wl_ext == '0) begin
      len = LenW'(1);
    end else if (wl_ext > LenW'(MaxWindow)) begin
      len = LenW'(MaxWindow);
    end else begin
      len = wl_ext;
    end
    wp_eff = (LenW'(wp_q) >= len) ? '0 : wp_q;
    wp_inc = LenW'(wp_eff) + LenW'(1);
    wp_d   = (wp_inc == len) ? '0 : wp_inc[AddrW-1:0];
    fill_d = (LenW'(fill_q) < len) ? CntW'(LenW'(fill_q) + LenW'(1)) : CntW'(len);
  end

  assign accept = sample_i.valid && sample_i.ready;
  assign store  = accept && sample_i.climate_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (store) begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

  assign addr_last  = (CntW'(addr_q + CntW'(1)) == fill_q);
  assign lanes_busy = |lane_busy;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (store) state_d = ST_SCAN;
      ST_SCAN:   if (addr_last) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_START;
      ST_START:  state_d = ST_DIVIDE;
      ST_DIVIDE: if (!lanes_busy) state_d = ST_EMIT;
      ST_EMIT:   if (load && chan_q == CH_GAS) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    sample_i.ready = (state_q == ST_IDLE);
    rd_issue       = (state_q == ST_SCAN);
    load           = (state_q == ST_EMIT) && (!out_valid_q || result_o.ready);
    ctl.clear      = store;
    ctl.rd_vld     = rd_vld_q;
    ctl.div_start  = (state_q == ST_START);
  end

  // Sequencer registers: state, walk address, read-valid pipe, result channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      chan_q   <= CH_TEMP;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_issue;
      if (store) begin
        addr_q <= '0;
        chan_q <= CH_TEMP;
      end else begin
        if (rd_issue) begin
          addr_q <= addr_q + CntW'(1);
        end
        if (load) begin
          chan_q <= chan_e'(2'(chan_q + 2'd1));
        end
      end
    end
  end

  // Lanes, one per channel
  wss_lane #(.MaxWindow (MaxWindow), .ValW (TempW), .SignedVal (1'b1)) u_lane_temp (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (ctl), .we_i (store), .waddr_i (wp_eff),
    .wval_i (sample_i.temperature_tenths), .wflag_i (1'b1),
    .raddr_i (addr_q[AddrW-1:0]),
    .min_o (lane_min[CH_TEMP]), .max_o (lane_max[CH_TEMP]), .mean_o (lane_mean[CH_TEMP]),
    .cnt_o (lane_cnt[CH_TEMP]), .busy_o (lane_busy[CH_TEMP])
  );

  wss_lane #(.MaxWindow (MaxWindow), .ValW (HumW), .SignedVal (1'b0)) u_lane_hum (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (ctl), .we_i (store), .waddr_i (wp_eff),
    .wval_i (sample_i.humidity_tenths), .wflag_i (1'b1),
    .raddr_i (addr_q[AddrW-1:0]),
    .min_o (lane_min[CH_HUM]), .max_o (lane_max[CH_HUM]), .mean_o (lane_mean[CH_HUM]),
    .cnt_o (lane_cnt[CH_HUM]), .busy_o (lane_busy[CH_HUM])
  );

  wss_lane #(.MaxWindow (MaxWindow), .ValW (LightW), .SignedVal (1'b0)) u_lane_light (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (ctl), .we_i (store), .waddr_i (wp_eff),
    .wval_i (sample_i.light_level), .wflag_i (1'b1),
    .raddr_i (addr_q[AddrW-1:0]),
    .min_o (lane_min[CH_LIGHT]), .max_o (lane_max[CH_LIGHT]),
    .mean_o (lane_mean[CH_LIGHT]),
    .cnt_o (lane_cnt[CH_LIGHT]), .busy_o (lane_busy[CH_LIGHT])
  );

  wss_lane #(.MaxWindow (MaxWindow), .ValW (GasW), .SignedVal (1'b0)) u_lane_gas (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (ctl), .we_i (store), .waddr_i (wp_eff),
    .wval_i (sample_i.gas_ppb), .wflag_i (sample_i.gas_ok),
    .raddr_i (addr_q[AddrW-1:0]),
    .min_o (lane_min[CH_GAS]), .max_o (lane_max[CH_GAS]), .mean_o (lane_mean[CH_GAS]),
    .cnt_o (lane_cnt[CH_GAS]), .busy_o (lane_busy[CH_GAS])
  );

  // Merge: pick the lane for this channel; a lane with no entries reports zeros
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_chan_q <= chan_q;
      out_last_q <= (chan_q == CH_GAS);
      out_used_q <= CfgW'(lane_cnt[chan_q]);
      if (lane_cnt[chan_q] == '0) begin
        out_min_q  <= '0;
        out_max_q  <= '0;
        out_mean_q <= '0;
        out_sv_q   <= 1'b0;
      end else begin
        out_min_q  <= lane_min[chan_q];
        out_max_q  <= lane_max[chan_q];
        out_mean_q <= lane_mean[chan_q];
        out_sv_q   <= 1'b1;
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.channel      = out_chan_q;
  assign result_o.minimum      = out_min_q;
  assign result_o.maximum      = out_max_q;
  assign result_o.mean         = out_mean_q;
  assign result_o.stat_valid   = out_sv_q;
  assign result_o.entries_used = out_used_q;
  assign result_o.last_of_run  = out_last_q;

  // Fill count never passes the ring depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MaxWindow))
    else $error("fill count beyond ring depth");

  // Temperature lane counts every stored entry of the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |-> (lane_cnt[CH_TEMP] == fill_q))
    else $error("walk count differs from fill count");

  // Only the gas result can lack statistics, and it closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.channel != CH_GAS) |->
      (result_o.stat_valid && !result_o.last_of_run && result_o.entries_used != '0))
    else $error("bad non-gas result");

  // Last gas result sends the sequencer back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && chan_q == CH_GAS) |=> (state_q == ST_IDLE))
    else $error("run did not end after gas result");

endmodule
